/* rtl/core/spi_ethernet_rx_deframer_unit_defines.svh */
// assertion macros shared by the deframer modules
`ifndef SPI_ETHERNET_RX_DEFRAMER_UNIT_DEFINES_SVH
`define SPI_ETHERNET_RX_DEFRAMER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define SED_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define SED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SED_ASSERT_IMPL(lbl, ante, cons, msg)
`define SED_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/sed_pkg.sv */
package sed_pkg;

	// item kinds on the input side
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_BYTE  = 2'd1;
	localparam logic [1:0] MODE_POP   = 2'd2;

	localparam int STAT_W  = 4;
	localparam int CNT_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int COPY_W  = 12;
	localparam int FLEN_W  = 11;
	localparam int POP_W   = COPY_W;

	// result codes
	localparam logic [STAT_W-1:0] ST_NONE       = 4'd0;
	localparam logic [STAT_W-1:0] ST_ACCEPTED   = 4'd1;
	localparam logic [STAT_W-1:0] ST_REJECTED   = 4'd2;
	localparam logic [STAT_W-1:0] ST_TAKEN      = 4'd3;
	localparam logic [STAT_W-1:0] ST_STORED     = 4'd4;
	localparam logic [STAT_W-1:0] ST_STORED_DROP = 4'd5;
	localparam logic [STAT_W-1:0] ST_LEN_ERR    = 4'd6;
	localparam logic [STAT_W-1:0] ST_START_ERR  = 4'd7;
	localparam logic [STAT_W-1:0] ST_END_ERR    = 4'd8;
	localparam logic [STAT_W-1:0] ST_BYTE       = 4'd9;
	localparam logic [STAT_W-1:0] ST_EMPTY      = 4'd10;
	localparam logic [STAT_W-1:0] ST_DISCARD    = 4'd11;

	// burst error codes, first one wins
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_LEN   = 2'd1;
	localparam logic [1:0] ERR_START = 2'd2;
	localparam logic [1:0] ERR_END   = 2'd3;

	localparam int ECHO_BYTES = 2;
	localparam int HDR_BYTES  = 12;
	localparam int END_BYTES  = 2;
	localparam int MIN_COUNT  = HDR_BYTES + END_BYTES;

	localparam logic [BYTE_W-1:0] START_MARK = 8'hAA;
	localparam logic [BYTE_W-1:0] END_MARK   = 8'h55;

	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_PTR_W = 2;

	typedef struct packed {
		logic              wr_en;
		logic              commit;
		logic [STAT_W-1:0] status;
	} parse_ctl_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] out_byte;
		logic              out_valid;
		logic              out_last;
		logic [FLEN_W-1:0] frame_length;
	} result_t;

endpackage

/* rtl/core/spi_ethernet_rx_deframer_unit.sv */
// result path: each result word is registered in the ring read stage and then written to the result
// fifo, which drives the master side
// throughput: one word per cycle sustained while m_tready stays high; the frame store has one read
// and one write port and each word touches each at most once, so nothing iterates
// stalls: a 3-word result fifo holds back-pressure, s_tready comes from registers only
// reset: arst_n clears ring pointers, burst state and fifo; store contents stay undefined
`include "spi_ethernet_rx_deframer_unit_defines.svh"

module spi_ethernet_rx_deframer_unit #(
	parameter int BUF_BYTES  = 2048,
	parameter int RING_SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // avail_count[15:0], data_byte[23:16], max_copy[35:24], zero pad
	input  logic [1:0]  s_tuser,   // mode[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte[7:0], out_valid[8], frame_length[19:9], zero pad
	output logic [3:0]  m_tuser,   // status[3:0]
	output logic        m_tlast    // out_last
);

	localparam int OFF_W = $clog2(BUF_BYTES);
	localparam int LEN_W = $clog2(BUF_BYTES + 1);

	// input word split into fields
	logic                              accept;
	logic [1:0]                        mode;
	logic [sed_pkg::CNT_W-1:0]         avail_count;
	logic [sed_pkg::BYTE_W-1:0]        data_byte;
	logic [sed_pkg::COPY_W-1:0]        max_copy;

	// parser to ring
	sed_pkg::parse_ctl_t               ctl;
	logic [OFF_W-1:0]                  wr_off;
	logic [sed_pkg::BYTE_W-1:0]        wr_data;
	logic [LEN_W-1:0]                  commit_len;

	// ring result, one per accepted word
	logic                              res_valid;
	sed_pkg::result_t                  res;

	// output side
	sed_pkg::result_t                  out_res;
	logic [sed_pkg::FIFO_PTR_W-1:0]    fifo_count;

	assign mode        = s_tuser;
	assign avail_count = s_tdata[15:0];
	assign data_byte   = s_tdata[23:16];
	assign max_copy    = s_tdata[35:24];

	// room check counts the word already in flight in the read stage,
	// so an accepted word always finds a free fifo entry when it leaves the read stage
	assign s_tready = (3'(fifo_count) + 3'(res_valid)) <= 3'(sed_pkg::FIFO_DEPTH - 1);
	assign accept   = s_tvalid && s_tready;

	// header checks, burst position and the payload write offset
	sed_parse #(
		.BUF_BYTES (BUF_BYTES)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mode        (mode),
		.avail_count (avail_count),
		.data_byte   (data_byte),
		.ctl         (ctl),
		.wr_off      (wr_off),
		.wr_data     (wr_data),
		.commit_len  (commit_len)
	);

	// frame store memory, slot lengths, ring pointers and the pop side;
	// the store read is registered, so the result leaves one stage later
	sed_ring #(
		.BUF_BYTES  (BUF_BYTES),
		.RING_SLOTS (RING_SLOTS)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode),
		.max_copy   (max_copy),
		.ctl        (ctl),
		.wr_off     (wr_off),
		.wr_data    (wr_data),
		.commit_len (commit_len),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result fifo, decouples the master side from the input side
	sed_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res),
		.count     (fifo_count)
	);

	assign m_tdata = {4'b0000, out_res.frame_length, out_res.out_valid, out_res.out_byte};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.out_last;

endmodule

/* rtl/core/sed_parse.sv */
`include "spi_ethernet_rx_deframer_unit_defines.svh"

module sed_parse #(
	parameter int BUF_BYTES = 2048,
	localparam int OFF_W = $clog2(BUF_BYTES),
	localparam int LEN_W = $clog2(BUF_BYTES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [1:0]                  mode,
	input  logic [sed_pkg::CNT_W-1:0]   avail_count,
	input  logic [sed_pkg::BYTE_W-1:0]  data_byte,
	output sed_pkg::parse_ctl_t         ctl,
	output logic [OFF_W-1:0]            wr_off,
	output logic [sed_pkg::BYTE_W-1:0]  wr_data,
	output logic [LEN_W-1:0]            commit_len
);

	localparam int POS_W = $clog2(BUF_BYTES + 2);

	logic                      active_q;
	logic [sed_pkg::CNT_W-1:0] count_q;
	logic [POS_W-1:0]          pos_q;
	logic [sed_pkg::CNT_W-1:0] payload_q;
	logic [1:0]                err_q;

	logic [POS_W-1:0]          k;
	logic [POS_W-1:0]          j;
	logic                      final_b;
	logic                      in_range;
	logic [sed_pkg::CNT_W-1:0] pay_d;
	logic [1:0]                err_d;
	logic                      wr_hit;
	logic [sed_pkg::BYTE_W-1:0] expect_b;

	assign k = pos_q - POS_W'(sed_pkg::ECHO_BYTES);
	assign j = pos_q - POS_W'(sed_pkg::ECHO_BYTES + sed_pkg::HDR_BYTES);
	assign final_b = (17'(pos_q) + 17'd1) >= (17'(count_q) + 17'(sed_pkg::ECHO_BYTES));
	assign in_range = (avail_count >= 16'(sed_pkg::MIN_COUNT))
		&& (17'(avail_count) <= 17'(BUF_BYTES));

	// per-byte header, payload and trailer checks
	always_comb begin
		pay_d    = payload_q;
		err_d    = err_q;
		wr_hit   = 1'b0;
		expect_b = '0;
		if (pos_q >= POS_W'(sed_pkg::ECHO_BYTES)) begin
			if (k < POS_W'(4)) begin
				if (k == POS_W'(0)) begin
					expect_b = count_q[7:0];
				end else if (k == POS_W'(1)) begin
					expect_b = count_q[15:8];
				end
				if (data_byte != expect_b && err_q == sed_pkg::ERR_OK) begin
					err_d = sed_pkg::ERR_LEN;
				end
			end else if (k < POS_W'(8)) begin
				if (data_byte != sed_pkg::START_MARK && err_q == sed_pkg::ERR_OK) begin
					err_d = sed_pkg::ERR_START;
				end
			end else if (k == POS_W'(8)) begin
				pay_d = {8'h00, data_byte};
			end else if (k == POS_W'(9)) begin
				pay_d = {data_byte, payload_q[7:0]};
				// frame must fit inside the burst
				if ((17'(pay_d) + 17'(sed_pkg::MIN_COUNT)) > 17'(count_q)
						&& err_q == sed_pkg::ERR_OK) begin
					err_d = sed_pkg::ERR_END;
				end
			end else if (k >= POS_W'(sed_pkg::HDR_BYTES) && err_q == sed_pkg::ERR_OK) begin
				if (17'(j) < 17'(payload_q)) begin
					wr_hit = 1'b1;
				end else if (17'(j) < (17'(payload_q) + 17'(sed_pkg::END_BYTES))) begin
					if (data_byte != sed_pkg::END_MARK) begin
						err_d = sed_pkg::ERR_END;
					end
				end
			end
		end
	end

	always_comb begin
		ctl.wr_en  = 1'b0;
		ctl.commit = 1'b0;
		ctl.status = sed_pkg::ST_NONE;
		if (accept) begin
			case (mode)
				sed_pkg::MODE_START: begin
					ctl.status = in_range ? sed_pkg::ST_ACCEPTED : sed_pkg::ST_REJECTED;
				end
				sed_pkg::MODE_BYTE: begin
					if (active_q) begin
						ctl.wr_en = wr_hit;
						if (!final_b) begin
							ctl.status = sed_pkg::ST_TAKEN;
						end else begin
							case (err_d)
								sed_pkg::ERR_LEN:   ctl.status = sed_pkg::ST_LEN_ERR;
								sed_pkg::ERR_START: ctl.status = sed_pkg::ST_START_ERR;
								sed_pkg::ERR_END:   ctl.status = sed_pkg::ST_END_ERR;
								default:            ctl.commit = 1'b1;
							endcase
						end
					end
				end
				default: begin
					ctl.status = sed_pkg::ST_NONE;
				end
			endcase
		end
	end

	assign wr_off     = OFF_W'(j);
	assign wr_data    = data_byte;
	assign commit_len = LEN_W'(payload_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			count_q   <= '0;
			pos_q     <= '0;
			payload_q <= '0;
			err_q     <= sed_pkg::ERR_OK;
		end else if (accept) begin
			if (mode == sed_pkg::MODE_START) begin
				active_q <= in_range;
				if (in_range) begin
					count_q   <= avail_count;
					pos_q     <= '0;
					payload_q <= '0;
					err_q     <= sed_pkg::ERR_OK;
				end
			end else if (mode == sed_pkg::MODE_BYTE && active_q) begin
				pos_q     <= pos_q + 1'b1;
				payload_q <= pay_d;
				err_q     <= err_d;
				if (final_b) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	`SED_ASSERT_IMPL(a_pos_in_burst, active_q, 17'(pos_q) <= (17'(count_q) + 17'd1), "burst position ran past the count")

endmodule

/* rtl/core/sed_ring.sv */
`include "spi_ethernet_rx_deframer_unit_defines.svh"

module sed_ring #(
	parameter int BUF_BYTES = 2048,
	parameter int RING_SLOTS = 4,
	localparam int OFF_W = $clog2(BUF_BYTES),
	localparam int LEN_W = $clog2(BUF_BYTES + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [1:0]                   mode,
	input  logic [sed_pkg::COPY_W-1:0]   max_copy,
	input  sed_pkg::parse_ctl_t          ctl,
	input  logic [OFF_W-1:0]             wr_off,
	input  logic [sed_pkg::BYTE_W-1:0]   wr_data,
	input  logic [LEN_W-1:0]             commit_len,
	output logic                         res_valid,
	output sed_pkg::result_t             res
);

	localparam int SLOT_W    = $clog2(RING_SLOTS);
	localparam int ADDR_W    = SLOT_W + OFF_W;
	localparam int MEM_DEPTH = RING_SLOTS * (2 ** OFF_W);

	// frame store, one region of 2**OFF_W bytes per slot
	logic [sed_pkg::BYTE_W-1:0] store_q [MEM_DEPTH];
	logic [LEN_W-1:0]           len_q [RING_SLOTS];

	logic [SLOT_W-1:0]          wr_q;
	logic [SLOT_W-1:0]          rd_q;
	logic [sed_pkg::POP_W-1:0]  pop_q;

	logic [SLOT_W-1:0]          wr_d;
	logic [SLOT_W-1:0]          rd_d;
	logic [sed_pkg::POP_W-1:0]  pop_d;

	logic                       v_s2;
	logic [sed_pkg::STAT_W-1:0] st_s2;
	logic                       byte_s2;
	logic                       last_s2;
	logic [sed_pkg::FLEN_W-1:0] flen_s2;
	logic [sed_pkg::BYTE_W-1:0] rd_data_s2;

	logic [sed_pkg::STAT_W-1:0] st_d;
	logic                       byte_d;
	logic                       last_d;
	logic [sed_pkg::FLEN_W-1:0] flen_d;

	logic                       empty;
	logic [LEN_W-1:0]           cur_len;
	logic [15:0]                len16;
	logic [15:0]                lim16;
	logic [15:0]                copy16;
	logic                       drop;
	logic                       last_b;
	logic                       rd_en;
	logic                       wr_we;
	logic                       len_we;
	logic [SLOT_W-1:0]          wr_inc;
	logic [SLOT_W-1:0]          rd_inc;
	logic [ADDR_W-1:0]          waddr;
	logic [ADDR_W-1:0]          raddr;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	assign wr_inc  = slot_inc(wr_q);
	assign rd_inc  = slot_inc(rd_q);
	assign empty   = (rd_q == wr_q);
	assign cur_len = len_q[rd_q];
	assign len16   = 16'(cur_len);
	assign lim16   = 16'(max_copy);
	assign copy16  = (len16 > lim16) ? lim16 : len16;
	assign drop    = (16'(pop_q) >= copy16) || (17'(pop_q) >= 17'(BUF_BYTES));
	assign last_b  = (17'(pop_q) + 17'd1) >= 17'(copy16);

	assign wr_we = accept && ctl.wr_en;
	assign waddr = {wr_q, wr_off};
	assign raddr = {rd_q, OFF_W'(pop_q)};

	always_comb begin
		st_d   = ctl.status;
		byte_d = 1'b0;
		last_d = 1'b0;
		flen_d = '0;
		rd_en  = 1'b0;
		len_we = 1'b0;
		wr_d   = wr_q;
		rd_d   = rd_q;
		pop_d  = pop_q;
		if (accept) begin
			if (mode == sed_pkg::MODE_POP) begin
				if (empty) begin
					st_d = sed_pkg::ST_EMPTY;
				end else if (drop) begin
					st_d   = sed_pkg::ST_DISCARD;
					flen_d = sed_pkg::FLEN_W'(cur_len);
					rd_d   = rd_inc;
					pop_d  = '0;
				end else begin
					st_d   = sed_pkg::ST_BYTE;
					byte_d = 1'b1;
					last_d = last_b;
					flen_d = sed_pkg::FLEN_W'(cur_len);
					rd_en  = 1'b1;
					if (last_b) begin
						rd_d  = rd_inc;
						pop_d = '0;
					end else begin
						pop_d = pop_q + 1'b1;
					end
				end
			end else if (ctl.commit) begin
				len_we = 1'b1;
				wr_d   = wr_inc;
				if (wr_inc == rd_q) begin
					// ring full: oldest frame goes
					st_d  = sed_pkg::ST_STORED_DROP;
					rd_d  = rd_inc;
					pop_d = '0;
				end else begin
					st_d = sed_pkg::ST_STORED;
				end
			end
		end
	end

	// read slot never equals write slot while a frame is held, so no bypass
	always_ff @(posedge clk) begin
		if (wr_we) begin
			store_q[waddr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s2 <= store_q[raddr];
		end
		if (len_we) begin
			len_q[wr_q] <= commit_len;
		end
		st_s2   <= st_d;
		byte_s2 <= byte_d;
		last_s2 <= last_d;
		flen_s2 <= flen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			pop_q <= '0;
			v_s2  <= 1'b0;
		end else begin
			wr_q  <= wr_d;
			rd_q  <= rd_d;
			pop_q <= pop_d;
			v_s2  <= accept;
		end
	end

	assign res_valid        = v_s2;
	assign res.status       = st_s2;
	assign res.out_byte     = byte_s2 ? rd_data_s2 : '0;
	assign res.out_valid    = byte_s2;
	assign res.out_last     = last_s2;
	assign res.frame_length = flen_s2;

	`SED_ASSERT_IMPL(a_rw_split, wr_we && rd_en, wr_q != rd_q, "store read and write hit the same slot")
	`SED_ASSERT_IMPL(a_offset_held, pop_q != '0, rd_q != wr_q, "pop offset set on an empty ring")

endmodule

/* rtl/core/sed_fifo.sv */
`include "spi_ethernet_rx_deframer_unit_defines.svh"

module sed_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  sed_pkg::result_t                 push_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output sed_pkg::result_t                 out_data,
	output logic [sed_pkg::FIFO_PTR_W-1:0]   count
);

	sed_pkg::result_t                 entry_q [sed_pkg::FIFO_DEPTH];
	logic [sed_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [sed_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [sed_pkg::FIFO_PTR_W-1:0]   count_q;
	logic                             pop;

	function automatic logic [sed_pkg::FIFO_PTR_W-1:0] ptr_inc(
		input logic [sed_pkg::FIFO_PTR_W-1:0] p);
		return (p == sed_pkg::FIFO_PTR_W'(sed_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SED_ASSERT_IMPL(a_no_overflow, push, (count_q != sed_pkg::FIFO_PTR_W'(sed_pkg::FIFO_DEPTH)) || pop, "result fifo overflow")
	`SED_ASSERT_NEXT(a_grow, push && !pop, count_q == ($past(count_q) + 2'd1), "fifo count did not grow on push")

endmodule
